FILE: hdl/psrt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psrt_pkg: shared definitions for the PPPoE session relay table
// Status and opcode codes, sequencer states and the stored entry layouts.
// ---------------------------------------------------------------------------
package psrt_pkg;

    localparam int SESSIONS_DEF = 256;
    localparam logic [8:0] CAP_RESET = 9'd256;

    localparam logic [1:0] OP_FWD    = 2'd0;
    localparam logic [1:0] OP_CLOSE  = 2'd1;
    localparam logic [1:0] OP_CREATE = 2'd2;

    localparam logic [2:0] ST_MISS    = 3'd0;
    localparam logic [2:0] ST_CLI_HIT = 3'd1;
    localparam logic [2:0] ST_SRV_HIT = 3'd2;
    localparam logic [2:0] ST_CREATED = 3'd3;
    localparam logic [2:0] ST_DUP     = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_REFUSED = 3'd6;

    localparam logic REG_CAP = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLI,
        S_SC_RD,
        S_SC_CMP,
        S_SRV_CHK,
        S_BLK_CHK,
        S_SEARCH,
        S_STL_LD,
        S_ADV
    } t_state;

    typedef enum logic [1:0] {
        M_SRV,
        M_BLK,
        M_STALE,
        M_INS
    } t_mode;

    // one session slot; a key word is mac<<16 | sid
    typedef struct packed {
        logic [63:0] ckey;
        logic [31:0] ciface;
        logic [63:0] skey;
        logic [31:0] siface;
        logic [47:0] cl_mac;
        logic [47:0] sl_mac;
        logic [63:0] gen;
    } t_slot;

    // one server-key index entry
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] iface;
        logic [15:0] slot;
        logic [63:0] gen;
    } t_cam;

endpackage

FILE: hdl/pppoe_session_relay_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pppoe_session_relay_table: PPPoE relay session table
// Lookup, close and create of client/server session pairs.
// ---------------------------------------------------------------------------
// Usage:
//  - A transaction is taken at a rising edge with start high and busy low.
//    busy stays high while the sequencer works on it.
//  - Each result is shown for one cycle with o_done high; the receiver
//    cannot stall, so nothing is ever held back.
//  - Client-side lookups read the slot memory and compare in state S_CLI.
//  - Server-side lookups scan the index memory one entry at a time through
//    the single key comparator.
//  - Creates chain up to four index scans (server key, collision scan with
//    a slot read per candidate, stale entry drop, insert) plus a walk of up
//    to capacity slot ids.
//  - Reset (synchronous, active low) clears every active, written and index
//    valid bit at once, the cursor, the generation counter and capacity
//    (to 256); no clearing pass is needed.
//  - session_capacity is written over the APB port at address 0; the user
//    must write it only while idle, as the block itself does not enforce it.
// ---------------------------------------------------------------------------
module pppoe_session_relay_table #(
    parameter int SESSIONS = psrt_pkg::SESSIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_roles,
    input  logic [31:0] i_iface,
    input  logic [47:0] i_peer_mac,
    input  logic [15:0] i_session_id,
    input  logic [31:0] i_client_iface,
    input  logic [47:0] i_client_mac,
    input  logic [47:0] i_client_local_mac,
    input  logic [47:0] i_server_local_mac,
    // result channel
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_iface,
    output logic [15:0] o_out_session_id,
    output logic [47:0] o_out_src_mac,
    output logic [47:0] o_out_dst_mac,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = $clog2(SESSIONS + 1);            // slot index bits
    localparam int EW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam logic [16:0] NMAX = 17'(SESSIONS);

    // stores
    psrt_pkg::t_slot slot_mem [SESSIONS+1];
    psrt_pkg::t_cam  cam_mem  [SESSIONS];
    logic [SESSIONS:0]   r_active;
    logic [SESSIONS:0]   r_written;     // slot data has been stored once
    logic [SESSIONS:0]   r_blocked;
    logic [SESSIONS-1:0] r_valid;

    psrt_pkg::t_slot r_slot_q;
    psrt_pkg::t_cam  r_cam_q;

    psrt_pkg::t_state r_state, n_state;
    psrt_pkg::t_mode  r_mode;

    // latched transaction
    logic [1:0]  r_op, r_roles;
    logic [31:0] r_iface, r_ci;
    logic [63:0] r_kw;
    logic [47:0] r_cmac, r_clm, r_slm;
    logic [15:0] r_sid;
    logic        r_cli_ok;

    // scan target and walk state
    logic [31:0]   r_t_iface;
    logic [63:0]   r_t_kw;
    logic [EW-1:0] r_e, r_free_e;
    logic          r_free_ok;
    logic [SW-1:0] r_s, r_k, r_cnt, r_found, r_cursor;
    logic [63:0]   r_ent_gen, r_stale_gen, r_gen;
    logic [8:0]    r_cap;

    logic [2:0]  r_o_status;
    logic [31:0] r_o_iface;
    logic [15:0] r_o_sid;
    logic [47:0] r_o_src, r_o_dst;
    logic        r_o_done;

    logic          accept, cfg_wr;
    logic [SW-1:0] slot_ra;
    logic          cam_hit, e_last, slot_ok, blk_cand, cli_hit, srv_live, blk_live;
    logic          cap_bad, free_now, k_free, cnt_last, dup, ins_ok, ins_do;
    logic [16:0]   cap17, start17;
    logic [SW-1:0] start_k, k_next;
    logic [15:0]   cam_k;
    logic [EW-1:0] ins_e;

    assign accept = start && !busy;
    assign busy   = (r_state != psrt_pkg::S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == psrt_pkg::REG_CAP);
    assign prdata = (paddr[2] == psrt_pkg::REG_CAP) ? {23'd0, r_cap} : 32'd0;

    // shared key comparator and helpers
    assign cam_hit  = r_valid[r_e] && r_cam_q.key == r_t_kw && r_cam_q.iface == r_t_iface;
    assign e_last   = (r_e == EW'(SESSIONS - 1));
    assign slot_ok  = ({1'b0, r_cam_q.slot} <= NMAX);
    assign cam_k    = r_cam_q.key[15:0];
    assign cap17    = {8'd0, r_cap};
    assign blk_cand = r_valid[r_e] && r_cam_q.iface == r_ci && r_cam_q.key[63:16] == r_cmac
                      && cam_k != 16'd0 && {1'b0, cam_k} <= cap17 && slot_ok;
    assign cli_hit  = r_cli_ok && r_active[r_sid[SW-1:0]] && r_slot_q.ckey == r_kw
                      && r_slot_q.ciface == r_iface;
    assign srv_live = r_active[r_s] && r_slot_q.gen == r_ent_gen && r_slot_q.skey == r_t_kw
                      && r_slot_q.siface == r_t_iface;
    assign blk_live = r_active[r_s] && r_slot_q.gen == r_cam_q.gen
                      && r_slot_q.skey == r_cam_q.key && r_slot_q.siface == r_cam_q.iface;
    assign dup      = r_slot_q.ciface == r_ci && r_slot_q.ckey[63:16] == r_cmac;
    assign cap_bad  = (r_cap == 9'd0) || (cap17 > NMAX);
    assign start17  = 17'(r_cursor) + 17'd1;
    assign start_k  = (start17 > cap17) ? SW'(1) : start17[SW-1:0];
    assign k_free   = !r_blocked[r_k] && !r_active[r_k];
    assign cnt_last = (17'(r_cnt) + 17'd1 == cap17);
    assign k_next   = (17'(r_k) == cap17) ? SW'(1) : r_k + SW'(1);
    assign free_now = !r_valid[r_e];
    assign ins_ok   = cam_hit || r_free_ok || free_now;
    assign ins_e    = (cam_hit || !r_free_ok) ? r_e : r_free_e;
    // insert only once the scan has settled on an entry
    assign ins_do   = ins_ok && (cam_hit || e_last);

    always_comb begin
        unique case (r_state)
            psrt_pkg::S_IDLE:   slot_ra = i_session_id[SW-1:0];
            psrt_pkg::S_SC_CMP: slot_ra = r_cam_q.slot[SW-1:0];
            psrt_pkg::S_SEARCH: slot_ra = r_k;
            default:            slot_ra = r_s;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psrt_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_opcode == psrt_pkg::OP_CREATE ||
                        (i_opcode < psrt_pkg::OP_CREATE && i_roles[0])) begin
                        n_state = psrt_pkg::S_CLI;
                    end else if (i_opcode < psrt_pkg::OP_CREATE && i_roles[1]) begin
                        n_state = psrt_pkg::S_SC_RD;
                    end
                end
            end
            psrt_pkg::S_CLI: begin
                if (r_op == psrt_pkg::OP_CREATE) begin
                    n_state = cli_hit ? psrt_pkg::S_IDLE : psrt_pkg::S_SC_RD;
                end else begin
                    n_state = (!cli_hit && r_roles[1]) ? psrt_pkg::S_SC_RD : psrt_pkg::S_IDLE;
                end
            end
            psrt_pkg::S_SC_RD: n_state = psrt_pkg::S_SC_CMP;
            psrt_pkg::S_SC_CMP: begin
                unique case (r_mode)
                    psrt_pkg::M_SRV: begin
                        if (cam_hit && slot_ok) begin
                            n_state = psrt_pkg::S_SRV_CHK;
                        end else if (cam_hit || e_last) begin
                            n_state = (r_op == psrt_pkg::OP_CREATE && !cap_bad) ?
                                      psrt_pkg::S_SC_RD : psrt_pkg::S_IDLE;
                        end else begin
                            n_state = psrt_pkg::S_SC_RD;
                        end
                    end
                    psrt_pkg::M_BLK: begin
                        if (blk_cand)    n_state = psrt_pkg::S_BLK_CHK;
                        else if (e_last) n_state = psrt_pkg::S_SEARCH;
                        else             n_state = psrt_pkg::S_SC_RD;
                    end
                    psrt_pkg::M_STALE: begin
                        n_state = (cam_hit || e_last) ? psrt_pkg::S_ADV : psrt_pkg::S_SC_RD;
                    end
                    psrt_pkg::M_INS: begin
                        n_state = (cam_hit || e_last) ? psrt_pkg::S_IDLE : psrt_pkg::S_SC_RD;
                    end
                    default: n_state = psrt_pkg::S_IDLE;
                endcase
            end
            psrt_pkg::S_SRV_CHK: begin
                n_state = (r_op == psrt_pkg::OP_CREATE && !srv_live && !cap_bad) ?
                          psrt_pkg::S_SC_RD : psrt_pkg::S_IDLE;
            end
            psrt_pkg::S_BLK_CHK: n_state = e_last ? psrt_pkg::S_SEARCH : psrt_pkg::S_SC_RD;
            psrt_pkg::S_SEARCH: begin
                if (k_free) begin
                    n_state = r_written[r_k] ? psrt_pkg::S_STL_LD : psrt_pkg::S_ADV;
                end else if (cnt_last) begin
                    n_state = psrt_pkg::S_IDLE;
                end
            end
            psrt_pkg::S_STL_LD: n_state = psrt_pkg::S_SC_RD;
            psrt_pkg::S_ADV:    n_state = psrt_pkg::S_SC_RD;
            default:            n_state = psrt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memories: registered reads, one write port each
    always_ff @(posedge i_clk) begin
        r_slot_q <= slot_mem[slot_ra];
        r_cam_q  <= cam_mem[r_e];
        if (r_state == psrt_pkg::S_SC_CMP && r_mode == psrt_pkg::M_INS && ins_do) begin
            cam_mem[ins_e]    <= '{key: r_kw, iface: r_iface, slot: 16'(r_found), gen: r_gen};
            slot_mem[r_found] <= '{ckey: {r_cmac, 16'(r_found)}, ciface: r_ci,
                                   skey: r_kw, siface: r_iface, cl_mac: r_clm,
                                   sl_mac: r_slm, gen: r_gen};
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_written <= '0;
            r_valid   <= '0;
            r_cursor  <= '0;
            r_gen     <= '0;
            r_cap     <= psrt_pkg::CAP_RESET;
            r_o_done  <= 1'b0;
        end else begin
            r_o_done <= 1'b0;
            if (cfg_wr) begin
                r_cap <= pwdata[8:0];
            end
            unique case (r_state)
                psrt_pkg::S_IDLE: begin
                    if (accept && n_state == psrt_pkg::S_IDLE) begin
                        r_o_done <= 1'b1;               // nothing to try: miss
                    end
                end
                psrt_pkg::S_CLI: begin
                    if (n_state == psrt_pkg::S_IDLE) begin
                        r_o_done <= 1'b1;
                    end
                    if (cli_hit && r_op == psrt_pkg::OP_CLOSE) begin
                        r_active[r_sid[SW-1:0]] <= 1'b0;
                    end
                end
                psrt_pkg::S_SC_CMP: begin
                    if (n_state == psrt_pkg::S_IDLE) begin
                        r_o_done <= 1'b1;
                    end
                    if (r_mode == psrt_pkg::M_STALE && cam_hit &&
                        r_cam_q.slot == 16'(r_found) && r_cam_q.gen == r_stale_gen) begin
                        r_valid[r_e] <= 1'b0;
                    end
                    if (r_mode == psrt_pkg::M_INS && ins_do) begin
                        r_valid[ins_e]     <= 1'b1;
                        r_active[r_found]  <= 1'b1;
                        r_written[r_found] <= 1'b1;
                    end
                end
                psrt_pkg::S_SRV_CHK: begin
                    if (n_state == psrt_pkg::S_IDLE) begin
                        r_o_done <= 1'b1;
                    end
                    if (srv_live && r_op == psrt_pkg::OP_CLOSE) begin
                        r_active[r_s] <= 1'b0;
                    end
                end
                psrt_pkg::S_SEARCH: begin
                    if (n_state == psrt_pkg::S_IDLE) begin
                        r_o_done <= 1'b1;
                    end
                end
                psrt_pkg::S_ADV: begin
                    r_cursor <= r_found;
                    r_gen    <= r_gen + 64'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath and result registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            psrt_pkg::S_IDLE: begin
                if (accept) begin
                    r_op      <= i_opcode;
                    r_roles   <= i_roles;
                    r_iface   <= i_iface;
                    r_kw      <= {i_peer_mac, i_session_id};
                    r_sid     <= i_session_id;
                    r_ci      <= i_client_iface;
                    r_cmac    <= i_client_mac;
                    r_clm     <= i_client_local_mac;
                    r_slm     <= i_server_local_mac;
                    r_cli_ok  <= ({1'b0, i_session_id} <= NMAX);
                    r_t_iface <= i_iface;
                    r_t_kw    <= {i_peer_mac, i_session_id};
                    r_e       <= '0;
                    r_mode    <= psrt_pkg::M_SRV;
                    r_o_status <= psrt_pkg::ST_MISS;
                    r_o_iface  <= '0;
                    r_o_sid    <= '0;
                    r_o_src    <= '0;
                    r_o_dst    <= '0;
                end
            end
            psrt_pkg::S_CLI: begin
                if (cli_hit && r_op == psrt_pkg::OP_CREATE) begin
                    r_o_status <= psrt_pkg::ST_REFUSED;
                end else if (cli_hit) begin
                    r_o_status <= psrt_pkg::ST_CLI_HIT;
                    r_o_iface  <= r_slot_q.siface;
                    r_o_sid    <= r_slot_q.skey[15:0];
                    r_o_src    <= r_slot_q.sl_mac;
                    r_o_dst    <= r_slot_q.skey[63:16];
                end
            end
            psrt_pkg::S_SC_CMP: begin
                r_s       <= r_cam_q.slot[SW-1:0];
                r_ent_gen <= r_cam_q.gen;
                if (n_state == psrt_pkg::S_SC_RD) begin
                    r_e <= r_e + EW'(1);
                end
                unique case (r_mode)
                    psrt_pkg::M_SRV: begin
                        if (!(cam_hit && slot_ok) && (cam_hit || e_last)) begin
                            if (r_op == psrt_pkg::OP_CREATE) begin
                                if (cap_bad) begin
                                    r_o_status <= psrt_pkg::ST_REFUSED;
                                end else begin
                                    r_blocked <= '0;
                                    r_e       <= '0;
                                    r_mode    <= psrt_pkg::M_BLK;
                                end
                            end
                        end
                    end
                    psrt_pkg::M_BLK: begin
                        if (!blk_cand && e_last) begin
                            r_k   <= start_k;
                            r_cnt <= '0;
                        end
                    end
                    psrt_pkg::M_INS: begin
                        if (free_now && !r_free_ok) begin
                            r_free_e  <= r_e;
                            r_free_ok <= 1'b1;
                        end
                        if (ins_do) begin
                            r_o_status <= psrt_pkg::ST_CREATED;
                            r_o_sid    <= 16'(r_found);
                        end else if (e_last) begin
                            r_o_status <= psrt_pkg::ST_REFUSED;
                        end
                    end
                    default: ;
                endcase
            end
            psrt_pkg::S_SRV_CHK: begin
                if (srv_live && r_op == psrt_pkg::OP_CREATE) begin
                    r_o_status <= dup ? psrt_pkg::ST_DUP : psrt_pkg::ST_REFUSED;
                    r_o_sid    <= dup ? r_slot_q.ckey[15:0] : 16'd0;
                end else if (srv_live) begin
                    r_o_status <= psrt_pkg::ST_SRV_HIT;
                    r_o_iface  <= r_slot_q.ciface;
                    r_o_sid    <= r_slot_q.ckey[15:0];
                    r_o_src    <= r_slot_q.cl_mac;
                    r_o_dst    <= r_slot_q.ckey[63:16];
                end else if (r_op == psrt_pkg::OP_CREATE) begin
                    if (cap_bad) begin
                        r_o_status <= psrt_pkg::ST_REFUSED;
                    end else begin
                        r_blocked <= '0;
                        r_e       <= '0;
                        r_mode    <= psrt_pkg::M_BLK;
                    end
                end
            end
            psrt_pkg::S_BLK_CHK: begin
                // id k would collide with a live server entry
                if (blk_live) begin
                    r_blocked[cam_k[SW-1:0]] <= 1'b1;
                end
                if (e_last) begin
                    r_k   <= start_k;
                    r_cnt <= '0;
                end else begin
                    r_e <= r_e + EW'(1);
                end
            end
            psrt_pkg::S_SEARCH: begin
                if (k_free) begin
                    r_found <= r_k;
                    r_s     <= r_k;
                end else if (cnt_last) begin
                    r_o_status <= psrt_pkg::ST_FULL;
                end else begin
                    r_k   <= k_next;
                    r_cnt <= r_cnt + SW'(1);
                end
            end
            psrt_pkg::S_STL_LD: begin
                r_t_kw      <= r_slot_q.skey;
                r_t_iface   <= r_slot_q.siface;
                r_stale_gen <= r_slot_q.gen;
                r_e         <= '0;
                r_mode      <= psrt_pkg::M_STALE;
            end
            psrt_pkg::S_ADV: begin
                r_t_kw    <= r_kw;
                r_t_iface <= r_iface;
                r_e       <= '0;
                r_free_ok <= 1'b0;
                r_mode    <= psrt_pkg::M_INS;
            end
            default: ;
        endcase
    end

    assign o_done           = r_o_done;
    assign o_status         = r_o_status;
    assign o_out_iface      = r_o_iface;
    assign o_out_session_id = r_o_sid;
    assign o_out_src_mac    = r_o_src;
    assign o_out_dst_mac    = r_o_dst;

    // a result only follows an accepted transaction or sequencer work
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_done |-> $past(accept) || $past(r_state != psrt_pkg::S_IDLE))
        else $error("result strobe without a transaction");

    // the generation only moves in S_ADV, when a slot is picked for allocation
    a_gen_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gen != $past(r_gen)) |-> $past(r_state == psrt_pkg::S_ADV))
        else $error("generation changed outside allocation");

    // a created client id is never zero
    a_created_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_done && r_o_status == psrt_pkg::ST_CREATED) |-> (r_o_sid != 16'd0))
        else $error("created session with id zero");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the PPPoE session relay table
// Drives lookup, close and create transactions and sets the session capacity
// over APB. A behavioural copy of the table predicts every result, and each
// o_done strobe is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;

    localparam int NSESS       = psrt_pkg::SESSIONS_DEF;
    localparam int STALL_LIMIT = 60000;   // cycles with no accepted command and no result

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  roles;
        logic [31:0] ifc;
        logic [47:0] mac;
        logic [15:0] sid;
        logic [31:0] cifc;
        logic [47:0] cmac;
        logic [47:0] clmac;
        logic [47:0] slmac;
    } t_relay_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ifc;
        logic [15:0] sid;
        logic [47:0] src;
        logic [47:0] dst;
    } t_relay_result;

    // one session known to be created, kept so lookups can aim at it
    typedef struct packed {
        logic [31:0] cifc;
        logic [47:0] cmac;
        logic [15:0] cid;
        logic [31:0] sifc;
        logic [47:0] smac;
        logic [15:0] ssid;
    } t_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_relay_cmd  cmd;
    logic        o_done;
    t_relay_result res;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pppoe_session_relay_table dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (cmd.op),
        .i_roles            (cmd.roles),
        .i_iface            (cmd.ifc),
        .i_peer_mac         (cmd.mac),
        .i_session_id       (cmd.sid),
        .i_client_iface     (cmd.cifc),
        .i_client_mac       (cmd.cmac),
        .i_client_local_mac (cmd.clmac),
        .i_server_local_mac (cmd.slmac),
        .o_done             (o_done),
        .o_status           (res.status),
        .o_out_iface        (res.ifc),
        .o_out_session_id   (res.sid),
        .o_out_src_mac      (res.src),
        .o_out_dst_mac      (res.dst),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Shadow copy of the session table. Slots 0..NSESS, the client session
    // id is the slot number; key words are {mac, sid}.
    // -----------------------------------------------------------------------
    logic        sess_active [0:NSESS];
    logic [63:0] cli_key     [0:NSESS];
    logic [31:0] cli_ifc     [0:NSESS];
    logic [63:0] srv_key     [0:NSESS];
    logic [31:0] srv_ifc     [0:NSESS];
    logic [47:0] cli_local   [0:NSESS];
    logic [47:0] srv_local   [0:NSESS];
    logic [63:0] sess_gen    [0:NSESS];
    // server-key index
    logic        idx_valid [0:NSESS-1];
    logic [63:0] idx_key   [0:NSESS-1];
    logic [31:0] idx_ifc   [0:NSESS-1];
    logic [15:0] idx_slot  [0:NSESS-1];
    logic [63:0] idx_gen   [0:NSESS-1];
    logic [15:0] alloc_ptr;
    logic [63:0] gen_count;
    logic [8:0]  capacity;

    t_relay_result expected_results[$];
    t_pair         live_pairs[$];
    int            mismatches;
    int            sent_items;
    int            checked_results;
    int            creates_ok;
    int            hits;
    int            idle_pct;
    int            stall_cycles;

    function automatic void clear_table();
        for (int s = 0; s <= NSESS; s++) begin
            sess_active[s] = 1'b0; cli_key[s] = '0; cli_ifc[s] = '0;
            srv_key[s] = '0; srv_ifc[s] = '0; cli_local[s] = '0;
            srv_local[s] = '0; sess_gen[s] = '0;
        end
        for (int e = 0; e < NSESS; e++) begin
            idx_valid[e] = 1'b0; idx_key[e] = '0; idx_ifc[e] = '0;
            idx_slot[e] = '0; idx_gen[e] = '0;
        end
        alloc_ptr = '0;
        gen_count = '0;
        capacity  = psrt_pkg::CAP_RESET;
    endfunction

    function automatic int index_find(logic [31:0] ifc, logic [63:0] kw);
        for (int e = 0; e < NSESS; e++)
            if (idx_valid[e] && idx_key[e] == kw && idx_ifc[e] == ifc)
                return e;
        return -1;
    endfunction

    // slot reached through the index while that slot is still the same session
    function automatic int server_slot(logic [31:0] ifc, logic [63:0] kw);
        int e;
        int s;
        e = index_find(ifc, kw);
        if (e < 0) return -1;
        s = idx_slot[e];
        if (s > NSESS) return -1;
        if (sess_active[s] && sess_gen[s] == idx_gen[e] && srv_key[s] == kw
            && srv_ifc[s] == ifc)
            return s;
        return -1;
    endfunction

    function automatic int client_slot(logic [31:0] ifc, logic [63:0] kw);
        int s;
        s = kw[15:0];
        if (s > NSESS) return -1;
        if (sess_active[s] && cli_key[s] == kw && cli_ifc[s] == ifc) return s;
        return -1;
    endfunction

    function automatic t_relay_result create_session(t_relay_cmd c);
        t_relay_result r;
        logic [63:0]   skw;
        int            s;
        int            e;
        int            first;
        int            k;
        int            found;
        r   = '0;
        skw = {c.mac, c.sid};
        if (client_slot(c.ifc, skw) >= 0) begin
            r.status = psrt_pkg::ST_REFUSED;
            return r;
        end
        s = server_slot(c.ifc, skw);
        if (s >= 0) begin
            if (cli_ifc[s] == c.cifc && cli_key[s][63:16] == c.cmac) begin
                r.status = psrt_pkg::ST_DUP;
                r.sid    = cli_key[s][15:0];
            end else begin
                r.status = psrt_pkg::ST_REFUSED;
            end
            return r;
        end
        if (capacity == 0 || capacity > NSESS) begin
            r.status = psrt_pkg::ST_REFUSED;
            return r;
        end
        // round robin from just past the last allocation
        first = alloc_ptr + 1;
        if (first > capacity) first = 1;
        found = 0;
        for (int i = 0; i < capacity && found == 0; i++) begin
            k = first + i;
            if (k > capacity) k -= capacity;
            if (server_slot(c.cifc, {c.cmac, 16'(k)}) < 0 && !sess_active[k])
                found = k;
        end
        if (found == 0) begin
            r.status = psrt_pkg::ST_FULL;
            return r;
        end
        e = index_find(srv_ifc[found], srv_key[found]);
        if (e >= 0 && idx_slot[e] == found && idx_gen[e] == sess_gen[found])
            idx_valid[e] = 1'b0;
        alloc_ptr = 16'(found);
        gen_count = gen_count + 1;
        e = index_find(c.ifc, skw);
        if (e < 0)
            for (int f = 0; f < NSESS; f++)
                if (!idx_valid[f]) begin
                    e = f;
                    break;
                end
        if (e < 0) begin
            r.status = psrt_pkg::ST_REFUSED;
            return r;
        end
        idx_valid[e] = 1'b1; idx_key[e] = skw; idx_ifc[e] = c.ifc;
        idx_slot[e] = 16'(found); idx_gen[e] = gen_count;
        sess_active[found] = 1'b1;
        cli_key[found]     = {c.cmac, 16'(found)};
        cli_ifc[found]     = c.cifc;
        srv_key[found]     = skw;
        srv_ifc[found]     = c.ifc;
        cli_local[found]   = c.clmac;
        srv_local[found]   = c.slmac;
        sess_gen[found]    = gen_count;
        r.status = psrt_pkg::ST_CREATED;
        r.sid    = 16'(found);
        return r;
    endfunction

    function automatic t_relay_result relay_outcome(t_relay_cmd c);
        t_relay_result r;
        logic [63:0]   kw;
        int            s;
        r  = '0;
        kw = {c.mac, c.sid};
        if (c.op == psrt_pkg::OP_CREATE) return create_session(c);
        if (c.op != psrt_pkg::OP_FWD && c.op != psrt_pkg::OP_CLOSE)
            return r;                                     // unused opcode: miss
        s = c.roles[0] ? client_slot(c.ifc, kw) : -1;
        if (s >= 0) begin
            r = '{psrt_pkg::ST_CLI_HIT, srv_ifc[s], srv_key[s][15:0], srv_local[s],
                  srv_key[s][63:16]};
        end else begin
            s = c.roles[1] ? server_slot(c.ifc, kw) : -1;
            if (s >= 0)
                r = '{psrt_pkg::ST_SRV_HIT, cli_ifc[s], cli_key[s][15:0], cli_local[s],
                      cli_key[s][63:16]};
        end
        if (s >= 0 && c.op == psrt_pkg::OP_CLOSE) sess_active[s] = 1'b0;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Sender: optional random gap, then present the transaction and hold it
    // until taken. Prediction happens at the accepting edge.
    // -----------------------------------------------------------------------
    task automatic send_cmd(t_relay_cmd c);
        t_relay_result r;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge i_clk); while (busy);
        r = relay_outcome(c);
        expected_results.push_back(r);
        sent_items++;
        if (c.op == psrt_pkg::OP_CREATE && r.status == psrt_pkg::ST_CREATED) begin
            creates_ok++;
            live_pairs.push_back('{c.cifc, c.cmac, r.sid, c.ifc, c.mac, c.sid});
            if (live_pairs.size() > 48) void'(live_pairs.pop_front());
        end
    endtask

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), $urandom};
    endfunction

    task automatic send_lookup(logic [1:0] op, logic [1:0] roles, logic [31:0] ifc,
                               logic [47:0] mac, logic [15:0] sid);
        t_relay_cmd c;
        c = '{op, roles, ifc, mac, sid, $urandom, rand_mac(), rand_mac(), rand_mac()};
        send_cmd(c);
    endtask

    task automatic send_create(logic [31:0] sifc, logic [47:0] smac, logic [15:0] ssid,
                               logic [31:0] cifc, logic [47:0] cmac);
        t_relay_cmd c;
        c = '{psrt_pkg::OP_CREATE, 2'($urandom), sifc, smac, ssid, cifc, cmac, rand_mac(),
              rand_mac()};
        send_cmd(c);
    endtask

    // wait until every prediction is met and the sequencer is back to idle
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [8:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * psrt_pkg::REG_CAP);
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity = value;
    endtask

    // -----------------------------------------------------------------------
    // Result checker: every strobe must meet the oldest prediction.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: %p", res);
            end else begin
                t_relay_result exp_r;
                exp_r = expected_results.pop_front();
                checked_results++;
                if (res.status inside {psrt_pkg::ST_CLI_HIT, psrt_pkg::ST_SRV_HIT}) hits++;
                if (res !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d expected %p got %p",
                                 checked_results, exp_r, res);
                end
            end
        end
    end

    // watchdog: no accepted command and no result for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog expired after %0d quiet cycles", STALL_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_basic_pairs();
        t_pair p;
        // all-ones server key and interface, then an ordinary pair
        send_create('1, '1, 16'hFFFF, 32'h1, 48'h0000_0000_0001);
        send_create(32'h10, 48'hA0, 16'h0, '1, '1);
        send_create(32'h10, 48'hA0, 16'h0, '1, '1);          // same pair: duplicate
        send_create(32'h10, 48'hA0, 16'h0, 32'h5, 48'h5);    // other client: refused
        p = live_pairs[live_pairs.size() - 1];
        send_create(p.cifc, p.cmac, p.cid, 32'h7, 48'h7);    // key live as client
        send_lookup(psrt_pkg::OP_FWD, 2'b01, p.cifc, p.cmac, p.cid);    // client hit
        send_lookup(psrt_pkg::OP_FWD, 2'b10, p.sifc, p.smac, p.ssid);   // server hit
        send_lookup(psrt_pkg::OP_FWD, 2'b00, p.cifc, p.cmac, p.cid);    // no roles: miss
        send_lookup(psrt_pkg::OP_FWD, 2'b10, p.cifc, p.cmac, p.cid);    // wrong side: miss
        send_lookup(2'd3, 2'b11, p.cifc, p.cmac, p.cid);                // unused opcode
        send_lookup(psrt_pkg::OP_FWD, 2'b11, '0, '0, 16'h0);            // session id zero
        send_lookup(psrt_pkg::OP_FWD, 2'b11, '1, '1, 16'hFFFF);         // id beyond table
        send_lookup(psrt_pkg::OP_FWD, 2'b01, 32'h1, 48'h1, 16'd257);
        send_lookup(psrt_pkg::OP_CLOSE, 2'b11, p.cifc, p.cmac, p.cid);  // close as client
        send_lookup(psrt_pkg::OP_FWD, 2'b11, p.cifc, p.cmac, p.cid);    // now gone
        send_lookup(psrt_pkg::OP_FWD, 2'b10, p.sifc, p.smac, p.ssid);   // stale index entry
        p = live_pairs[0];
        send_lookup(psrt_pkg::OP_CLOSE, 2'b10, p.sifc, p.smac, p.ssid); // close as server
        send_lookup(psrt_pkg::OP_FWD, 2'b11, p.sifc, p.smac, p.ssid);
    endtask

    task automatic test_capacity_edges();
        write_capacity(9'd0);
        send_create(32'h20, 48'hB0, 16'h1, 32'h21, 48'hC0);
        write_capacity(9'd257);
        send_create(32'h20, 48'hB0, 16'h1, 32'h21, 48'hC0);
        write_capacity(9'd511);
        send_create(32'h20, 48'hB0, 16'h1, 32'h21, 48'hC0);
        // single slot: fill it, find it full, free it, reuse it
        write_capacity(9'd1);
        send_create(32'h30, 48'hD0, 16'h2, 32'h31, 48'hE0);
        send_create(32'h32, 48'hD1, 16'h3, 32'h33, 48'hE1);
        send_lookup(psrt_pkg::OP_CLOSE, 2'b01, 32'h31, 48'hE0, 16'h1);
        send_create(32'h32, 48'hD1, 16'h3, 32'h33, 48'hE1);
        send_lookup(psrt_pkg::OP_FWD, 2'b10, 32'h30, 48'hD0, 16'h2);    // old server key gone
        write_capacity(psrt_pkg::CAP_RESET);
    endtask

    // mostly well-formed traffic on a few interfaces and MACs so that keys
    // collide, repeat and get closed; a fifth is unconstrained noise
    task automatic test_random_traffic(int n);
        t_relay_cmd c;
        t_pair      p;
        int         pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            c = '{2'($urandom), 2'($urandom), $urandom, rand_mac(), 16'($urandom),
                  $urandom, rand_mac(), rand_mac(), rand_mac()};
            if (pick < 40) begin
                c.op   = psrt_pkg::OP_CREATE;
                c.ifc  = 32'($urandom_range(1, 4));
                c.mac  = 48'($urandom_range(1, 4)) << 40;
                c.sid  = ($urandom_range(1)) ? 16'($urandom_range(8)) : 16'($urandom);
                c.cifc = 32'($urandom_range(1, 3));
                c.cmac = 48'h0100_0000_0000 | 48'($urandom_range(3));
                if (live_pairs.size() != 0 && $urandom_range(3) == 0) begin
                    p = live_pairs[$urandom_range(live_pairs.size() - 1)];
                    c.ifc = p.sifc; c.mac = p.smac; c.sid = p.ssid;
                    if ($urandom_range(1)) begin
                        c.cifc = p.cifc; c.cmac = p.cmac;
                    end
                end
            end else if (pick < 80 && live_pairs.size() != 0) begin
                p = live_pairs[$urandom_range(live_pairs.size() - 1)];
                c.op = ($urandom_range(3) == 0) ? psrt_pkg::OP_CLOSE : psrt_pkg::OP_FWD;
                if ($urandom_range(1)) begin
                    c.ifc = p.cifc; c.mac = p.cmac; c.sid = p.cid;
                end else begin
                    c.ifc = p.sifc; c.mac = p.smac; c.sid = p.ssid;
                end
            end
            send_cmd(c);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        mismatches = 0; sent_items = 0; checked_results = 0;
        creates_ok = 0; hits = 0; idle_pct = 11;
        clear_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_pairs();
        test_capacity_edges();
        test_random_traffic(200);
        idle_pct = 50;
        write_capacity(9'd6);            // small table: wrap-round and full
        test_random_traffic(200);
        idle_pct = 0;
        write_capacity(9'($urandom_range(2, 255)));
        test_random_traffic(100);
        write_capacity(psrt_pkg::CAP_RESET);
        test_random_traffic(100);
        drain();

        $display("covered %0d transactions, %0d results checked: %0d sessions created,",
                 sent_items, checked_results, creates_ok);
        $display("%0d lookup hits, capacities 0 to 511 across three idle patterns", hits);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d results never seen", mismatches,
                     expected_results.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
